// File: hdl/sqb_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sprite quad batcher.
package sqb_pkg;

  localparam int MAX_SPRITES      = 4096;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CNT_W      = $clog2(MAX_SPRITES + 1);
  localparam int ROM_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDX_PROD_W = 14 + ROM_IDX_W;
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [14:0] THRESHOLD_RESET = 15'd104;
  localparam longint      HALF_PI_Q30     = 64'sd1686629713;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint    a;
    longint    a2;
    longint    term;
    longint    sum;
    int        k;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      a    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      a2   = (a * a) >>> 30;
      term = a;
      sum  = a;
      term = ((term * a2) >>> 30) / 6;
      sum  = sum - term;
      term = ((term * a2) >>> 30) / 20;
      sum  = sum + term;
      term = ((term * a2) >>> 30) / 42;
      sum  = sum - term;
      term = ((term * a2) >>> 30) / 72;
      sum  = sum + term;
      term = ((term * a2) >>> 30) / 110;
      sum  = sum - term;
      term = ((term * a2) >>> 30) / 156;
      sum  = sum + term;
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 32768) sum = 32768;
      rom[k] = 16'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Q1.15 sine of a 16-bit turn angle
  function automatic logic signed [16:0] sine_lookup(input logic [15:0] h);
    logic [IDX_PROD_W-1:0] prod;
    logic [ROM_IDX_W-1:0]  idx;
    logic [ROM_IDX_W-1:0]  addr;
    logic signed [16:0]    mag;
    prod = IDX_PROD_W'(h[13:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    idx  = ROM_IDX_W'(prod >> 14);
    addr = h[14] ? (ROM_IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    mag  = $signed({1'b0, SINE_ROM[addr]});
    return h[15] ? -mag : mag;
  endfunction

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_height;
    logic signed [23:0] pos_z;
    logic [15:0]        size_x;
    logic [15:0]        size_z;
    logic signed [16:0] offset_x;
    logic signed [16:0] offset_z;
    logic [31:0]        uv_min;
    logic [31:0]        uv_max;
    logic signed [16:0] sin_q;
    logic signed [16:0] cos_q;
    logic               rot;
    logic [CNT_W-1:0]   sprite_idx;
    logic               opens;
    logic [14:0]        batch_first;
    logic [15:0]        batch_tex;
  } sqb_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sqb_qstat_t;

endpackage

// File: hdl/sqb_front.sv
// Front end: accepts sprite records, tracks batches and frame count, looks up sine and cosine.
module sqb_front
  import sqb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_height,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_size_x,
  input  logic [15:0]        in_size_z,
  input  logic signed [16:0] in_offset_x,
  input  logic signed [16:0] in_offset_z,
  input  logic [31:0]        in_uv_min,
  input  logic [31:0]        in_uv_max,
  input  logic signed [15:0] in_heading,
  input  logic [15:0]        in_texture_id,
  input  logic               in_frame_start,
  input  sqb_qstat_t         q_stat,
  output logic               push,
  output sqb_item_t          push_item
);

  logic [14:0]      thr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      cur_tex_r;
  logic [14:0]      batch_r;

  logic [CNT_W-1:0] cnt_eff;
  logic             frame_full;
  logic             opens;
  logic             accept;
  logic [16:0]      hd_mag;
  logic [15:0]      h_cos;
  logic [14:0]      batch_first;

  assign in_stall   = q_stat.full;
  assign accept     = in_valid && !in_stall;
  assign cnt_eff    = in_frame_start ? '0 : cnt_r;
  assign frame_full = cnt_eff >= CNT_W'(MAX_SPRITES);
  assign opens      = (cnt_eff == '0) || (in_texture_id != cur_tex_r);
  assign push       = accept && !frame_full;

  assign hd_mag = in_heading[15] ? (17'd0 - {in_heading[15], in_heading})
                                 : {1'b0, in_heading};
  assign h_cos  = in_heading + 16'h4000;

  assign batch_first = opens ? (15'({cnt_eff, 2'b00}) + 15'({cnt_eff, 1'b0}))
                             : (in_frame_start ? 15'd0 : batch_r);

  always_comb begin
    push_item             = '0;
    push_item.pos_x       = in_pos_x;
    push_item.pos_height  = in_pos_height;
    push_item.pos_z       = in_pos_z;
    push_item.size_x      = in_size_x;
    push_item.size_z      = in_size_z;
    push_item.offset_x    = in_offset_x;
    push_item.offset_z    = in_offset_z;
    push_item.uv_min      = in_uv_min;
    push_item.uv_max      = in_uv_max;
    push_item.sin_q       = sine_lookup(in_heading);
    push_item.cos_q       = sine_lookup(h_cos);
    push_item.rot         = hd_mag > {2'b00, thr_r};
    push_item.sprite_idx  = cnt_eff;
    push_item.opens       = opens;
    push_item.batch_first = batch_first;
    push_item.batch_tex   = opens ? in_texture_id : cur_tex_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      cnt_r     <= '0;
      cur_tex_r <= '0;
      batch_r   <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (push) begin
        cnt_r     <= cnt_eff + CNT_W'(1);
        cur_tex_r <= push_item.batch_tex;
        batch_r   <= batch_first;
      end
    end
  end

  a_push_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_item.sprite_idx < CNT_W'(MAX_SPRITES)))
    else $error("sprite pushed past frame capacity");

endmodule

// File: hdl/sqb_queue.sv
// Short queue of classified sprite records between front and back end.
module sqb_queue
  import sqb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sqb_item_t  push_item,
  input  logic       pop,
  output sqb_item_t  head_item,
  output sqb_qstat_t q_stat
);

  sqb_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_stat.full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = count_r == '0;
  assign head_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

// File: hdl/sqb_back.sv
// Back end: walks the four corners of each queued sprite, rotates and saturates, drives beats.
module sqb_back
  import sqb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sqb_item_t          head_item,
  input  sqb_qstat_t         q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_height,
  output logic signed [23:0] out_vert_z,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [13:0]        out_vertex_number,
  output logic               out_new_batch,
  output logic [14:0]        out_batch_first_index,
  output logic [15:0]        out_batch_texture,
  output logic               out_last_corner
);

  typedef struct packed {
    logic signed [34:0] p_xc;
    logic signed [34:0] p_zs;
    logic signed [34:0] p_xs;
    logic signed [34:0] p_zc;
    logic signed [17:0] dx;
    logic signed [17:0] dz;
    logic               rot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_height;
    logic signed [23:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [13:0]        vertex_number;
    logic               new_batch;
    logic [14:0]        batch_first;
    logic [15:0]        batch_tex;
    logic               last;
  } corner_t;

  function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
    if (v > 38'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -38'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  logic [1:0] corner_r;
  logic       s1_valid_r;
  corner_t    s1_r;
  corner_t    s1_nxt;
  logic       out_valid_r;

  logic               out_ready;
  logic               s1_ready;
  logic               issue;
  logic signed [17:0] dx;
  logic signed [17:0] dz;
  logic signed [35:0] sum_x;
  logic signed [35:0] sum_z;
  logic signed [35:0] rnd_x;
  logic signed [35:0] rnd_z;
  logic signed [37:0] vx;
  logic signed [37:0] vz;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign issue     = !q_stat.empty && s1_ready;
  assign pop       = issue && (corner_r == CORNER_LAST);
  assign out_valid = out_valid_r;

  assign dx = $signed({head_item.offset_x[16], head_item.offset_x})
            + $signed({2'b00, (corner_r[0] ? head_item.size_x : 16'd0)});
  assign dz = $signed({head_item.offset_z[16], head_item.offset_z})
            + $signed({2'b00, (corner_r[1] ? head_item.size_z : 16'd0)});

  always_comb begin
    s1_nxt               = '0;
    s1_nxt.p_xc          = dx * head_item.cos_q;
    s1_nxt.p_zs          = dz * head_item.sin_q;
    s1_nxt.p_xs          = dx * head_item.sin_q;
    s1_nxt.p_zc          = dz * head_item.cos_q;
    s1_nxt.dx            = dx;
    s1_nxt.dz            = dz;
    s1_nxt.rot           = head_item.rot;
    s1_nxt.pos_x         = head_item.pos_x;
    s1_nxt.pos_height    = head_item.pos_height;
    s1_nxt.pos_z         = head_item.pos_z;
    s1_nxt.tex_u         = corner_r[0] ? head_item.uv_max[31:16] : head_item.uv_min[31:16];
    s1_nxt.tex_v         = corner_r[1] ? head_item.uv_max[15:0] : head_item.uv_min[15:0];
    s1_nxt.vertex_number = 14'({head_item.sprite_idx, corner_r});
    s1_nxt.new_batch     = head_item.opens && (corner_r == CORNER_FIRST);
    s1_nxt.batch_first   = head_item.batch_first;
    s1_nxt.batch_tex     = head_item.batch_tex;
    s1_nxt.last          = corner_r == CORNER_LAST;
  end

  assign sum_x = $signed(s1_r.p_xc) - $signed(s1_r.p_zs);
  assign sum_z = $signed(s1_r.p_xs) + $signed(s1_r.p_zc);
  assign rnd_x = (sum_x + 36'sd16384) >>> 15;
  assign rnd_z = (sum_z + 36'sd16384) >>> 15;
  assign vx = $signed(s1_r.pos_x) + (s1_r.rot ? rnd_x : 36'($signed(s1_r.dx)));
  assign vz = $signed(s1_r.pos_z) + (s1_r.rot ? rnd_z : 36'($signed(s1_r.dz)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= CORNER_FIRST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        corner_r <= corner_r + 2'd1;
      end
      if (s1_ready) begin
        s1_valid_r <= issue;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= s1_nxt;
    end
    if (out_ready && s1_valid_r) begin
      out_vert_x            <= sat24(vx);
      out_vert_height       <= s1_r.pos_height;
      out_vert_z            <= sat24(vz);
      out_tex_u             <= s1_r.tex_u;
      out_tex_v             <= s1_r.tex_v;
      out_vertex_number     <= s1_r.vertex_number;
      out_new_batch         <= s1_r.new_batch;
      out_batch_first_index <= s1_r.batch_first;
      out_batch_texture     <= s1_r.batch_tex;
      out_last_corner       <= s1_r.last;
    end
  end

  a_last_is_corner3: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_corner) |-> (out_vertex_number[1:0] == CORNER_LAST))
    else $error("last corner flag on wrong corner");

  a_batch_on_corner0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_batch) |-> (out_vertex_number[1:0] == CORNER_FIRST))
    else $error("new batch flag off corner 0");

endmodule

// File: hdl/sprite_quad_batcher.sv
// Top level of the sprite quad batcher: front end, record queue and corner back end.
//
//  channel  dir  handshake         beat
//  in_*     in   in_valid/in_stall one sprite record
//  out_*    out  out_valid/out_stall one corner vertex
//  cfg_*    in   cfg_valid/cfg_ready rotate threshold write
//
// Each record yields four beats, one per cycle while out_stall is low, from the back end's
// single corner datapath; the first beat of a record is written into the queue, then the
// stage-one register, then the output registers before out_valid rises.
// Sine and cosine are looked up in the front end from a constant quarter-wave table.
// Reset is synchronous; the threshold comes up at 104, all counters at zero.
// The queue holds two records, one of them the record being expanded; input stalls
// once both slots are taken.
module sprite_quad_batcher
  import sqb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_height,
  input  logic signed [23:0] in_pos_z,
  input  logic [15:0]        in_size_x,
  input  logic [15:0]        in_size_z,
  input  logic signed [16:0] in_offset_x,
  input  logic signed [16:0] in_offset_z,
  input  logic [31:0]        in_uv_min,
  input  logic [31:0]        in_uv_max,
  input  logic signed [15:0] in_heading,
  input  logic [15:0]        in_texture_id,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_vert_x,
  output logic signed [23:0] out_vert_height,
  output logic signed [23:0] out_vert_z,
  output logic [15:0]        out_tex_u,
  output logic [15:0]        out_tex_v,
  output logic [13:0]        out_vertex_number,
  output logic               out_new_batch,
  output logic [14:0]        out_batch_first_index,
  output logic [15:0]        out_batch_texture,
  output logic               out_last_corner
);

  logic       push;
  logic       pop;
  sqb_item_t  push_item;
  sqb_item_t  head_item;
  sqb_qstat_t q_stat;

  assign cfg_ready = 1'b1;

  sqb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_height  (in_pos_height),
    .in_pos_z       (in_pos_z),
    .in_size_x      (in_size_x),
    .in_size_z      (in_size_z),
    .in_offset_x    (in_offset_x),
    .in_offset_z    (in_offset_z),
    .in_uv_min      (in_uv_min),
    .in_uv_max      (in_uv_max),
    .in_heading     (in_heading),
    .in_texture_id  (in_texture_id),
    .in_frame_start (in_frame_start),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  sqb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  sqb_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_item             (head_item),
    .q_stat                (q_stat),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_vert_x            (out_vert_x),
    .out_vert_height       (out_vert_height),
    .out_vert_z            (out_vert_z),
    .out_tex_u             (out_tex_u),
    .out_tex_v             (out_tex_v),
    .out_vertex_number     (out_vertex_number),
    .out_new_batch         (out_new_batch),
    .out_batch_first_index (out_batch_first_index),
    .out_batch_texture     (out_batch_texture),
    .out_last_corner       (out_last_corner)
  );

endmodule
